// ----- rtl/struct_block_token_scanner_core_assert.svh -----
// Assertion macros shared by the scanner RTL.
`ifndef STRUCT_BLOCK_TOKEN_SCANNER_CORE_ASSERT_SVH
`define STRUCT_BLOCK_TOKEN_SCANNER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SBTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scanner assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SBTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scanner assertion failed");

`endif

// ----- rtl/sbts_pkg.sv -----
package sbts_pkg;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_CHAR  = 2'd1,
    OP_END   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_SCAN   = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_REJECT = 2'd2,
    ST_IDLE   = 2'd3
  } status_t;

  typedef enum logic [8:0] {
    PH_IDLE        = 9'b000000001,
    PH_KEYWORD     = 9'b000000010,
    PH_AFTER_KW    = 9'b000000100,
    PH_AFTER_SLASH = 9'b000001000,
    PH_MAIN        = 9'b000010000,
    PH_CMT_BEGIN   = 9'b000100000,
    PH_LINE        = 9'b001000000,
    PH_BLOCK       = 9'b010000000,
    PH_BLOCK_END   = 9'b100000000
  } phase_t;

  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Index of the final character of the keyword.
  localparam logic [2:0] KW_LAST = 3'd5;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic       allowed;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       skipped;
  } out_item_t;

  // Scanner control state that does not depend on the depth width.
  typedef struct packed {
    phase_t     phase;
    logic [2:0] kw_idx;
    logic       in_body;
  } scan_ctl_t;

  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h73; // s
      3'd1:    c = 8'h74; // t
      3'd2:    c = 8'h72; // r
      3'd3:    c = 8'h75; // u
      3'd4:    c = 8'h63; // c
      3'd5:    c = 8'h74; // t
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'd32, [8'd9:8'd13]};
  endfunction

endpackage

// ----- rtl/sbts_step.sv -----
module sbts_step
  import sbts_pkg::*;
#(
  parameter int DEPTH_BITS = 8
) (
  input  in_item_t              item,
  input  scan_ctl_t             ctl_cur,
  input  logic [DEPTH_BITS-1:0] depth_cur,
  output scan_ctl_t             ctl_nxt,
  output logic [DEPTH_BITS-1:0] depth_nxt,
  output out_item_t             result
);

  localparam logic [DEPTH_BITS-1:0] DepthOne = DEPTH_BITS'(1);
  localparam logic [DEPTH_BITS-1:0] DepthMax = {DEPTH_BITS{1'b1}};

  logic [1:0] status;
  logic       skip;
  logic       idle;

  assign idle = (ctl_cur.phase == PH_IDLE);

  always_comb begin
    ctl_nxt   = ctl_cur;
    depth_nxt = depth_cur;
    status    = ST_SCAN;
    skip      = 1'b0;
    case (item.op)
      OP_BEGIN: begin
        ctl_nxt.kw_idx  = 3'd0;
        ctl_nxt.in_body = 1'b0;
        depth_nxt       = '0;
        ctl_nxt.phase   = item.allowed ? PH_KEYWORD : PH_IDLE;
        status          = item.allowed ? ST_SCAN : ST_IDLE;
      end
      OP_CHAR: begin
        case (ctl_cur.phase)
          PH_KEYWORD: begin
            if (ctl_cur.kw_idx == 3'd0 && is_space(item.ch)) begin
              skip = 1'b1;
            end else if (ctl_cur.kw_idx > KW_LAST ||
                         item.ch != kw_char(ctl_cur.kw_idx)) begin
              ctl_nxt.phase = PH_IDLE;
              status        = ST_REJECT;
            end else begin
              ctl_nxt.kw_idx = ctl_cur.kw_idx + 3'd1;
              if (ctl_cur.kw_idx == KW_LAST) begin
                ctl_nxt.phase = PH_AFTER_KW;
              end
            end
          end
          PH_AFTER_KW: begin
            if (is_space(item.ch)) begin
              ctl_nxt.phase = PH_MAIN;
            end else if (item.ch == CH_SLASH) begin
              ctl_nxt.phase = PH_AFTER_SLASH;
            end else begin
              ctl_nxt.phase = PH_IDLE;
              status        = ST_REJECT;
            end
          end
          PH_AFTER_SLASH: begin
            if (item.ch == CH_SLASH) begin
              ctl_nxt.phase = PH_LINE;
            end else if (item.ch == CH_STAR) begin
              ctl_nxt.phase = PH_BLOCK;
            end else begin
              ctl_nxt.phase = PH_IDLE;
              status        = ST_REJECT;
            end
          end
          PH_MAIN: begin
            if (!ctl_cur.in_body) begin
              if (item.ch == CH_LBRACE) begin
                depth_nxt       = DepthOne;
                ctl_nxt.in_body = 1'b1;
              end else if (item.ch == CH_RBRACE) begin
                ctl_nxt.phase = PH_IDLE;
                status        = ST_REJECT;
              end else if (item.ch == CH_SLASH) begin
                ctl_nxt.phase = PH_CMT_BEGIN;
              end
            end else begin
              if (item.ch == CH_RBRACE) begin
                if (depth_cur <= DepthOne) begin
                  depth_nxt     = '0;
                  ctl_nxt.phase = PH_IDLE;
                  status        = ST_ACCEPT;
                end else begin
                  depth_nxt = depth_cur - DepthOne;
                end
              end else if (item.ch == CH_LBRACE) begin
                // The depth saturates rather than wrapping.
                if (depth_cur != DepthMax) begin
                  depth_nxt = depth_cur + DepthOne;
                end
              end else if (item.ch == CH_SLASH) begin
                ctl_nxt.phase = PH_CMT_BEGIN;
              end
            end
          end
          PH_CMT_BEGIN: begin
            if (item.ch == CH_SLASH) begin
              ctl_nxt.phase = PH_LINE;
            end else if (item.ch == CH_STAR) begin
              ctl_nxt.phase = PH_BLOCK;
            end else begin
              ctl_nxt.phase = PH_MAIN;
            end
          end
          PH_LINE: begin
            if (item.ch == CH_NEWLINE) begin
              ctl_nxt.phase = PH_MAIN;
            end
          end
          PH_BLOCK: begin
            if (item.ch == CH_STAR) begin
              ctl_nxt.phase = PH_BLOCK_END;
            end
          end
          PH_BLOCK_END: begin
            // A second star does not keep the comment ready to close.
            ctl_nxt.phase = (item.ch == CH_SLASH) ? PH_MAIN : PH_BLOCK;
          end
          default: begin
            ctl_nxt.phase = PH_IDLE;
            status        = ST_IDLE;
          end
        endcase
      end
      OP_END: begin
        if (idle) begin
          status = ST_IDLE;
        end else begin
          ctl_nxt.phase = PH_IDLE;
          status        = ST_REJECT;
        end
      end
      default: begin
        status = idle ? ST_IDLE : ST_SCAN;
      end
    endcase
  end

  assign result.status  = status;
  assign result.skipped = skip;

endmodule

// ----- rtl/struct_block_token_scanner_core.sv -----
// Struct token scanner. Takes one character transaction per cycle and
// answers each with exactly one result transaction in the next cycle, from an
// output register; the scan state is updated in the same cycle as the input
// transaction is taken, so a new character may follow every cycle. The only
// stall comes from the result channel: while a result waits and out_ready is
// low, in_ready is low. DEPTH_BITS sets the width of the saturating brace
// depth counter.
`include "struct_block_token_scanner_core_assert.svh"

module struct_block_token_scanner_core
  import sbts_pkg::*;
#(
  parameter int DEPTH_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  scan_ctl_t             ctl_r;
  scan_ctl_t             ctl_nxt;
  logic [DEPTH_BITS-1:0] depth_r;
  logic [DEPTH_BITS-1:0] depth_nxt;
  out_item_t             res_nxt;
  out_item_t             out_data_r;
  logic                  out_valid_r;
  logic                  in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  sbts_step #(
    .DEPTH_BITS(DEPTH_BITS)
  ) u_step (
    .item      (in_data),
    .ctl_cur   (ctl_r),
    .depth_cur (depth_r),
    .ctl_nxt   (ctl_nxt),
    .depth_nxt (depth_nxt),
    .result    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.phase   <= PH_IDLE;
      ctl_r.kw_idx  <= 3'd0;
      ctl_r.in_body <= 1'b0;
      depth_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        ctl_r   <= ctl_nxt;
        depth_r <= depth_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A waiting result is never overwritten.
  `SBTS_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_valid_r && !out_ready, !in_ready)
  // A begin that is not allowed leaves the scanner idle.
  `SBTS_ASSERT_NEXT(a_begin_idle, clk, rst_n,
                    in_fire && in_data.op == OP_BEGIN && !in_data.allowed,
                    ctl_r.phase == PH_IDLE && out_data_r.status == ST_IDLE)
  // A finished token always returns the scanner to idle.
  `SBTS_ASSERT_NOW(a_finish_idle, clk, rst_n,
                   out_valid_r && $past(in_fire) &&
                   (out_data_r.status == ST_ACCEPT || out_data_r.status == ST_REJECT),
                   ctl_r.phase == PH_IDLE)
  // Skipped whitespace only occurs while the scan carries on.
  `SBTS_ASSERT_NOW(a_skip_scan, clk, rst_n, out_valid_r && out_data_r.skipped,
                   out_data_r.status == ST_SCAN)

endmodule
